// ----- rtl/uhp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UDP header parser package
// Shared types and protocol constants for the header parser and port filter.
// ----------------------------------------------------------------------------
package uhp_pkg;

  localparam int ETH_HDR_BYTES   = 14;
  localparam int MIN_FRAME_BYTES = 42;
  localparam int UDP_HDR_BYTES   = 8;
  localparam int IHL_BYTE_POS    = 14;
  localparam int PROTO_BYTE_POS  = 23;
  localparam int SRC_IP_POS      = 26;
  localparam int DEST_IP_POS     = 30;
  localparam int IP_END_POS      = 34;
  localparam int SRC_MAC_POS     = 6;
  localparam int ETYPE_POS       = 12;
  localparam int IHL_SHIFT       = 2;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [15:0] PORT_A         = 16'd8888;
  localparam logic [15:0] PORT_B         = 16'd53;
  localparam logic [15:0] PORT_C         = 16'd80;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic CFG_IDX_FILTER_MODE = 1'b0;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TOO_SHORT = 2'd1,
    STATUS_NOT_IPV4  = 2'd2,
    STATUS_NOT_UDP   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FILTER_PORT_8888 = 2'd0,
    FILTER_PORT_53   = 2'd1,
    FILTER_PORT_80   = 2'd2,
    FILTER_ALL_UDP   = 2'd3
  } filter_mode_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } frame_in_t;

  typedef struct packed {
    status_t     status;
    logic        accepted;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [31:0] src_ip;
    logic [31:0] dest_ip;
    logic [15:0] udp_src;
    logic [15:0] udp_dst;
    logic [15:0] payload_len;
  } frame_out_t;

  typedef struct packed {
    logic        too_short;
    logic [15:0] ethertype;
    logic [7:0]  protocol;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [31:0] src_ip;
    logic [31:0] dest_ip;
    logic [15:0] udp_src;
    logic [15:0] udp_dst;
    logic [15:0] udp_length;
  } hdr_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- rtl/uhp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UDP header parser front end
// Tracks the byte position, captures header fields and emits one record per frame.
// ----------------------------------------------------------------------------
module uhp_front #(
  parameter int MAX_FRAME_BYTES = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_acc,
  input  uhp_pkg::frame_in_t in_beat,
  output logic              rec_push,
  output uhp_pkg::hdr_rec_t rec
);
  import uhp_pkg::*;

  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

  logic [POS_W-1:0] pos_r, pos_nxt, len, udp_start;
  logic [15:0] etype_r, etype_nxt;
  logic [3:0]  hw_r, hw_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [47:0] dmac_r, dmac_nxt, smac_r, smac_nxt;
  logic [31:0] sip_r, sip_nxt, dip_r, dip_nxt;
  logic [15:0] sport_r, sport_nxt, dport_r, dport_nxt, ulen_r, ulen_nxt;
  logic        cap_en;
  logic [7:0]  b;

  always_comb begin
    b         = in_beat.frame_byte;
    cap_en    = pos_r < POS_W'(MAX_FRAME_BYTES);
    etype_nxt = etype_r;
    proto_nxt = proto_r;
    dmac_nxt  = dmac_r;
    smac_nxt  = smac_r;
    sip_nxt   = sip_r;
    dip_nxt   = dip_r;
    sport_nxt = sport_r;
    dport_nxt = dport_r;
    ulen_nxt  = ulen_r;
    hw_nxt    = (cap_en && pos_r == POS_W'(IHL_BYTE_POS)) ? b[3:0] : hw_r;
    udp_start = POS_W'(ETH_HDR_BYTES) + POS_W'({hw_nxt, 2'b00});
    if (cap_en) begin
      if (pos_r < POS_W'(SRC_MAC_POS)) begin
        dmac_nxt = {dmac_r[39:0], b};
      end else if (pos_r < POS_W'(ETYPE_POS)) begin
        smac_nxt = {smac_r[39:0], b};
      end else if (pos_r < POS_W'(ETH_HDR_BYTES)) begin
        etype_nxt = {etype_r[7:0], b};
      end else if (pos_r == POS_W'(PROTO_BYTE_POS)) begin
        proto_nxt = b;
      end else if (pos_r >= POS_W'(SRC_IP_POS) && pos_r < POS_W'(DEST_IP_POS)) begin
        sip_nxt = {sip_r[23:0], b};
      end else if (pos_r >= POS_W'(DEST_IP_POS) && pos_r < POS_W'(IP_END_POS)) begin
        dip_nxt = {dip_r[23:0], b};
      end
      if (pos_r >= udp_start) begin
        if (pos_r < udp_start + POS_W'(2)) begin
          sport_nxt = {sport_r[7:0], b};
        end else if (pos_r < udp_start + POS_W'(4)) begin
          dport_nxt = {dport_r[7:0], b};
        end else if (pos_r < udp_start + POS_W'(6)) begin
          ulen_nxt = {ulen_r[7:0], b};
        end
      end
    end
    len     = pos_r + POS_W'(cap_en);
    pos_nxt = len;
  end

  always_comb begin
    rec_push       = byte_acc && in_beat.last_byte;
    rec.too_short  = (len < POS_W'(MIN_FRAME_BYTES)) ||
                     (len < udp_start + POS_W'(UDP_HDR_BYTES));
    rec.ethertype  = etype_nxt;
    rec.protocol   = proto_nxt;
    rec.dst_mac    = dmac_nxt;
    rec.src_mac    = smac_nxt;
    rec.src_ip     = sip_nxt;
    rec.dest_ip    = dip_nxt;
    rec.udp_src    = sport_nxt;
    rec.udp_dst    = dport_nxt;
    rec.udp_length = ulen_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (byte_acc && in_beat.last_byte)) begin
      pos_r   <= '0;
      etype_r <= '0;
      hw_r    <= '0;
      proto_r <= '0;
      dmac_r  <= '0;
      smac_r  <= '0;
      sip_r   <= '0;
      dip_r   <= '0;
      sport_r <= '0;
      dport_r <= '0;
      ulen_r  <= '0;
    end else if (byte_acc) begin
      pos_r   <= pos_nxt;
      etype_r <= etype_nxt;
      hw_r    <= hw_nxt;
      proto_r <= proto_nxt;
      dmac_r  <= dmac_nxt;
      smac_r  <= smac_nxt;
      sip_r   <= sip_nxt;
      dip_r   <= dip_nxt;
      sport_r <= sport_nxt;
      dport_r <= dport_nxt;
      ulen_r  <= ulen_nxt;
    end
  end

endmodule

// ----- rtl/uhp_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UDP header parser record queue
// Small first-in first-out buffer of header records between front and back end.
// ----------------------------------------------------------------------------
module uhp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  uhp_pkg::hdr_rec_t wr_rec,
  input  logic              rd_en,
  output uhp_pkg::hdr_rec_t rd_rec,
  output uhp_pkg::q_stat_t  stat
);
  import uhp_pkg::*;

  hdr_rec_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_wr, do_rd;

  always_comb begin
    stat.full  = cnt_r == QCNT_W'(QUEUE_DEPTH);
    stat.empty = cnt_r == '0;
    do_wr      = wr_en && !stat.full;
    do_rd      = rd_en && !stat.empty;
    cnt_nxt    = cnt_r + QCNT_W'(do_wr) - QCNT_W'(do_rd);
    rd_rec     = mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_rec;
    end
  end

endmodule

// ----- rtl/uhp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UDP header parser back end
// Classifies a header record, applies the port filter and holds the result.
// ----------------------------------------------------------------------------
module uhp_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  uhp_pkg::hdr_rec_t     rec,
  input  logic                  q_empty,
  output logic                  q_pop,
  input  uhp_pkg::filter_mode_t filter_mode,
  input  logic                  out_pop,
  output logic                  out_empty,
  output uhp_pkg::frame_out_t   out_beat
);
  import uhp_pkg::*;

  frame_out_t res, out_r;
  logic       out_valid_r;
  logic       match;

  always_comb begin
    res = '0;
    if (rec.too_short) begin
      res.status = STATUS_TOO_SHORT;
    end else if (rec.ethertype != ETHERTYPE_IPV4) begin
      res.status = STATUS_NOT_IPV4;
    end else if (rec.protocol != PROTO_UDP) begin
      res.status = STATUS_NOT_UDP;
    end else begin
      res.status = STATUS_OK;
    end
    case (filter_mode)
      FILTER_PORT_8888: match = rec.udp_src == PORT_A || rec.udp_dst == PORT_A;
      FILTER_PORT_53:   match = rec.udp_src == PORT_B || rec.udp_dst == PORT_B;
      FILTER_PORT_80:   match = rec.udp_src == PORT_C || rec.udp_dst == PORT_C;
      default:          match = 1'b1;
    endcase
    if (res.status == STATUS_OK) begin
      res.accepted    = match;
      res.dst_mac     = rec.dst_mac;
      res.src_mac     = rec.src_mac;
      res.src_ip      = rec.src_ip;
      res.dest_ip     = rec.dest_ip;
      res.udp_src     = rec.udp_src;
      res.udp_dst     = rec.udp_dst;
      res.payload_len = (rec.udp_length >= 16'(UDP_HDR_BYTES)) ?
                        rec.udp_length - 16'(UDP_HDR_BYTES) : 16'd0;
    end
    q_pop     = !q_empty && (!out_valid_r || out_pop);
    out_empty = !out_valid_r;
    out_beat  = out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_r <= res;
    end
  end

endmodule

// ----- rtl/udp_header_parse_port_filter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UDP header parser and port filter
// Parses Ethernet, IPv4 and UDP headers from a byte stream and filters by port.
// ----------------------------------------------------------------------------
// Channel   Ports                               Beat
// input     push, full, in_data                 one frame byte and last flag
// result    empty, pop, out_data                one parse result per frame
// config    psel, penable, pwrite, paddr, ...   filter_mode at address 0
//
// One byte is taken every cycle while full is low. The edge that accepts a
// frame's last byte queues its record; the result register loads it when free.
// Full rises once four records wait in the queue behind a stalled result port,
// and then every input byte waits, also in the middle of a frame. Reset clears
// all frame state and sets filter_mode to accept all UDP traffic.
// ----------------------------------------------------------------------------
module udp_header_parse_port_filter_core #(
  parameter int MAX_FRAME_BYTES = 65536
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  uhp_pkg::frame_in_t                  in_data,
  output logic                                empty,
  input  logic                                pop,
  output uhp_pkg::frame_out_t                 out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [uhp_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [uhp_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [uhp_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import uhp_pkg::*;

  filter_mode_t filter_mode_r;
  hdr_rec_t     rec_in, rec_out;
  q_stat_t      q_stat;
  logic         rec_push, q_pop, byte_acc, cfg_wr;

  always_comb begin
    pready   = 1'b1;
    full     = q_stat.full;
    byte_acc = push && !q_stat.full;
    cfg_wr   = psel && penable && pwrite && pready;
    prdata   = (paddr[2] == CFG_IDX_FILTER_MODE) ?
               CFG_DATA_W'(filter_mode_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_mode_r <= FILTER_ALL_UDP;
    end else if (cfg_wr && paddr[2] == CFG_IDX_FILTER_MODE) begin
      filter_mode_r <= filter_mode_t'(pwdata[1:0]);
    end
  end

  uhp_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_acc (byte_acc),
    .in_beat  (in_data),
    .rec_push (rec_push),
    .rec      (rec_in)
  );

  uhp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (rec_push),
    .wr_rec (rec_in),
    .rd_en  (q_pop),
    .rd_rec (rec_out),
    .stat   (q_stat)
  );

  uhp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .rec         (rec_out),
    .q_empty     (q_stat.empty),
    .q_pop       (q_pop),
    .filter_mode (filter_mode_r),
    .out_pop     (pop),
    .out_empty   (empty),
    .out_beat    (out_data)
  );

endmodule

// ----- rtl/uhp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UDP header parser checker
// Port-level assertions for the header parser, attached to the top level.
// ----------------------------------------------------------------------------
module uhp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input uhp_pkg::frame_out_t out_data
);
  import uhp_pkg::*;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queue not idle after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_data))
    else $error("stalled result changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_data.status != STATUS_OK |->
      !out_data.accepted && out_data.udp_src == '0 && out_data.udp_dst == '0 &&
      out_data.payload_len == '0 && out_data.dst_mac == '0)
    else $error("failed frame carries fields");

  a_payload_max: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_data.payload_len <= 16'd65527)
    else $error("payload length out of range");

endmodule

bind udp_header_parse_port_filter_core uhp_checker u_uhp_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data)
);
